>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/spc_pkg.sv
package spc_pkg;

	// Default coordinate width and depth of the queue between front and back.
	localparam int COORD_WIDTH_DEF = 24;
	localparam int FIFO_DEPTH = 4;

	// Pair kinds.
	localparam logic [2:0] CMD_PT_PT     = 3'd0;
	localparam logic [2:0] CMD_PT_RECT   = 3'd1;
	localparam logic [2:0] CMD_PT_CIRC   = 3'd2;
	localparam logic [2:0] CMD_RECT_RECT = 3'd3;
	localparam logic [2:0] CMD_RECT_CIRC = 3'd4;
	localparam logic [2:0] CMD_CIRC_CIRC = 3'd5;

	// How the intersection point is formed.
	typedef enum logic [1:0] {
		PK_NONE,
		PK_RECT,
		PK_ALONG
	} pk_t;

	// Classification that the front hands to the back with each word.
	typedef struct packed {
		logic circ;
		logic hit_d;
		pk_t  pk;
	} ctrl_t;

endpackage

>>> rtl/spc_if.sv
// Channel carrying one shape pair word.
interface spc_in_if #(parameter int CW = spc_pkg::COORD_WIDTH_DEF);
	logic                 valid;
	logic                 ready;
	logic [2:0]           cmd;
	logic signed [CW-1:0] a_x;
	logic signed [CW-1:0] a_y;
	logic signed [CW-1:0] a_x2;
	logic signed [CW-1:0] a_y2;
	logic [CW-2:0]        a_radius;
	logic signed [CW-1:0] b_x;
	logic signed [CW-1:0] b_y;
	logic signed [CW-1:0] b_x2;
	logic signed [CW-1:0] b_y2;
	logic [CW-2:0]        b_radius;

	modport source (output valid, cmd, a_x, a_y, a_x2, a_y2, a_radius,
		b_x, b_y, b_x2, b_y2, b_radius, input ready);
	modport sink (input valid, cmd, a_x, a_y, a_x2, a_y2, a_radius,
		b_x, b_y, b_x2, b_y2, b_radius, output ready);
endinterface

// Channel carrying one result word.
interface spc_out_if #(parameter int CW = spc_pkg::COORD_WIDTH_DEF);
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 point_valid;
	logic signed [CW-1:0] hit_x;
	logic signed [CW-1:0] hit_y;

	modport source (output valid, hit, point_valid, hit_x, hit_y, input ready);
	modport sink (input valid, hit, point_valid, hit_x, hit_y, output ready);
endinterface

>>> rtl/spc_front.sv
module spc_front #(
	parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	spc_in_if.sink                        shapes,
	input  logic [$clog2(spc_pkg::FIFO_DEPTH+1)-1:0] fifo_count,
	output logic                          push,
	output spc_pkg::ctrl_t                ctrl,
	output logic signed [COORD_WIDTH-1:0] ox,
	output logic signed [COORD_WIDTH-1:0] oy,
	output logic [COORD_WIDTH:0]          mx,
	output logic [COORD_WIDTH:0]          my,
	output logic                          sgx,
	output logic                          sgy,
	output logic [COORD_WIDTH-2:0]        r,
	output logic [2*COORD_WIDTH+1:0]      sqx,
	output logic [2*COORD_WIDTH+1:0]      sqy,
	output logic [2*COORD_WIDTH-1:0]      tsq
);
	localparam int W = COORD_WIDTH;
	localparam int CNTW = $clog2(spc_pkg::FIFO_DEPTH + 1);

	logic                 accept;
	logic [CNTW:0]        inflight;
	logic                 v_s1;
	logic                 v_s2;

	spc_pkg::ctrl_t       ctrl_c;
	logic signed [W-1:0]  ox_c, oy_c;
	logic signed [W:0]    dx_c, dy_c;
	logic [W-2:0]         r_c;
	logic [W-1:0]         thr_c;

	logic signed [W:0]    ax_e, ay_e, bx_e, by_e, cx_e, cy_e, sumx, sumy;
	logic signed [W-1:0]  lx, rx, ty, by2m, cx, cy;

	spc_pkg::ctrl_t       ctrl_s1, ctrl_s2;
	logic signed [W-1:0]  ox_s1, oy_s1, ox_s2, oy_s2;
	logic signed [W:0]    dx_s1, dy_s1;
	logic [W-2:0]         r_s1, r_s2;
	logic [W-1:0]         thr_s1;
	logic [W:0]           mx_c, my_c, mx_s2, my_s2;
	logic                 sgx_s2, sgy_s2;
	logic [2*W+1:0]       sqx_c, sqy_c, sqx_s2, sqy_s2;
	logic [2*W-1:0]       tsq_c, tsq_s2;

	// Credit check: every word in flight in the front must find room in the queue.
	assign inflight = (CNTW+1)'(fifo_count) + (CNTW+1)'(v_s1) + (CNTW+1)'(v_s2);
	assign shapes.ready = inflight < (CNTW+1)'(spc_pkg::FIFO_DEPTH);
	assign accept = shapes.valid && shapes.ready;

	// Operand preparation: extended coordinates, overlap bounds and clamp.
	always_comb begin
		ax_e = {shapes.a_x[W-1], shapes.a_x};
		ay_e = {shapes.a_y[W-1], shapes.a_y};
		bx_e = {shapes.b_x[W-1], shapes.b_x};
		by_e = {shapes.b_y[W-1], shapes.b_y};
		lx   = (shapes.a_x > shapes.b_x) ? shapes.a_x : shapes.b_x;
		rx   = (shapes.a_x2 < shapes.b_x2) ? shapes.a_x2 : shapes.b_x2;
		ty   = (shapes.a_y > shapes.b_y) ? shapes.a_y : shapes.b_y;
		by2m = (shapes.a_y2 < shapes.b_y2) ? shapes.a_y2 : shapes.b_y2;
		sumx = {lx[W-1], lx} + {rx[W-1], rx};
		sumy = {ty[W-1], ty} + {by2m[W-1], by2m};
		cx   = (shapes.b_x < shapes.a_x) ? shapes.a_x :
			((shapes.b_x > shapes.a_x2) ? shapes.a_x2 : shapes.b_x);
		cy   = (shapes.b_y < shapes.a_y) ? shapes.a_y :
			((shapes.b_y > shapes.a_y2) ? shapes.a_y2 : shapes.b_y);
		cx_e = {cx[W-1], cx};
		cy_e = {cy[W-1], cy};
	end

	// Pair kind decoder: direct tests settle here, distance tests go on.
	always_comb begin
		ctrl_c = '{circ: 1'b0, hit_d: 1'b0, pk: spc_pkg::PK_NONE};
		ox_c   = '0;
		oy_c   = '0;
		dx_c   = '0;
		dy_c   = '0;
		r_c    = '0;
		thr_c  = '0;
		unique case (shapes.cmd)
			spc_pkg::CMD_PT_PT: begin
				ctrl_c.hit_d = (shapes.a_x == shapes.b_x) && (shapes.a_y == shapes.b_y);
			end
			spc_pkg::CMD_PT_RECT: begin
				ctrl_c.hit_d = !(shapes.a_x < shapes.b_x || shapes.a_x > shapes.b_x2 ||
					shapes.a_y < shapes.b_y || shapes.a_y > shapes.b_y2);
			end
			spc_pkg::CMD_PT_CIRC: begin
				ctrl_c.circ = 1'b1;
				dx_c  = ax_e - bx_e;
				dy_c  = ay_e - by_e;
				thr_c = {1'b0, shapes.b_radius};
			end
			spc_pkg::CMD_RECT_RECT: begin
				ctrl_c.hit_d = !(shapes.a_x > shapes.b_x2 || shapes.a_y > shapes.b_y2 ||
					shapes.a_x2 < shapes.b_x || shapes.a_y2 < shapes.b_y);
				ctrl_c.pk = spc_pkg::PK_RECT;
				ox_c = sumx[W:1];
				oy_c = sumy[W:1];
			end
			spc_pkg::CMD_RECT_CIRC: begin
				ctrl_c.circ = 1'b1;
				ctrl_c.pk   = spc_pkg::PK_ALONG;
				ox_c  = shapes.b_x;
				oy_c  = shapes.b_y;
				dx_c  = cx_e - bx_e;
				dy_c  = cy_e - by_e;
				r_c   = shapes.b_radius;
				thr_c = {1'b0, shapes.b_radius};
			end
			spc_pkg::CMD_CIRC_CIRC: begin
				ctrl_c.circ = 1'b1;
				ctrl_c.pk   = spc_pkg::PK_ALONG;
				ox_c  = shapes.a_x;
				oy_c  = shapes.a_y;
				dx_c  = bx_e - ax_e;
				dy_c  = by_e - ay_e;
				r_c   = shapes.a_radius;
				thr_c = {1'b0, shapes.a_radius} + {1'b0, shapes.b_radius};
			end
			default: begin
				ctrl_c.hit_d = 1'b0;
			end
		endcase
	end

	// Magnitudes and squares for the second stage.
	always_comb begin
		mx_c  = dx_s1[W] ? (W+1)'(-dx_s1) : (W+1)'(dx_s1);
		my_c  = dy_s1[W] ? (W+1)'(-dy_s1) : (W+1)'(dy_s1);
		sqx_c = {{(W+1){1'b0}}, mx_c} * {{(W+1){1'b0}}, mx_c};
		sqy_c = {{(W+1){1'b0}}, my_c} * {{(W+1){1'b0}}, my_c};
		tsq_c = {{W{1'b0}}, thr_s1} * {{W{1'b0}}, thr_s1};
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl_c;
		ox_s1   <= ox_c;
		oy_s1   <= oy_c;
		dx_s1   <= dx_c;
		dy_s1   <= dy_c;
		r_s1    <= r_c;
		thr_s1  <= thr_c;
		ctrl_s2 <= ctrl_s1;
		ox_s2   <= ox_s1;
		oy_s2   <= oy_s1;
		r_s2    <= r_s1;
		mx_s2   <= mx_c;
		my_s2   <= my_c;
		sgx_s2  <= dx_s1[W];
		sgy_s2  <= dy_s1[W];
		sqx_s2  <= sqx_c;
		sqy_s2  <= sqy_c;
		tsq_s2  <= tsq_c;
	end

	assign push = v_s2;
	assign ctrl = ctrl_s2;
	assign ox   = ox_s2;
	assign oy   = oy_s2;
	assign mx   = mx_s2;
	assign my   = my_s2;
	assign sgx  = sgx_s2;
	assign sgy  = sgy_s2;
	assign r    = r_s2;
	assign sqx  = sqx_s2;
	assign sqy  = sqy_s2;
	assign tsq  = tsq_s2;
endmodule

>>> rtl/spc_fifo.sv
module spc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = spc_pkg::FIFO_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             din,
	input  logic                         pop,
	output logic [WIDTH-1:0]             dout,
	output logic                         nonempty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CNTW-1:0]  cnt_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + CNTW'(push) - CNTW'(pop);
		end
	end

	// Word storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

	assign dout     = mem_q[rd_q];
	assign nonempty = cnt_q != '0;
	assign count    = cnt_q;
endmodule

>>> rtl/spc_sqrt.sv
module spc_sqrt #(
	parameter int N_BITS = 50,
	parameter int PW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                v_in,
	input  logic [N_BITS-1:0]   rad_in,
	input  logic [PW-1:0]       pay_in,
	output logic                v_out,
	output logic [N_BITS/2-1:0] root_out,
	output logic [PW-1:0]       pay_out
);
	localparam int RB = N_BITS / 2;
	localparam int RW = RB + 2;

	logic              v_s    [0:RB-1];
	logic [N_BITS-1:0] rad_s  [0:RB-1];
	logic [RW-1:0]     rem_s  [0:RB-1];
	logic [RB-1:0]     root_s [0:RB-1];
	logic [PW-1:0]     pay_s  [0:RB-1];

	// One root bit per stage, two radicand bits brought down each time.
	for (genvar k = 0; k < RB; k++) begin : g_stage
		logic              cur_v;
		logic [N_BITS-1:0] cur_rad;
		logic [RW-1:0]     cur_rem;
		logic [RB-1:0]     cur_root;
		logic [PW-1:0]     cur_pay;
		logic [RW-1:0]     rem_t, trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_v    = v_in;
			assign cur_rad  = rad_in;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_pay  = pay_in;
		end else begin : g_next
			assign cur_v    = v_s[k-1];
			assign cur_rad  = rad_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_pay  = pay_s[k-1];
		end

		assign rem_t = {cur_rem[RW-3:0], cur_rad[N_BITS-1 -: 2]};
		assign trial = {cur_root, 2'b01};
		assign ge    = rem_t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= cur_rad << 2;
				rem_s[k]  <= ge ? rem_t - trial : rem_t;
				root_s[k] <= {cur_root[RB-2:0], ge};
				pay_s[k]  <= cur_pay;
			end
		end
	end

	assign v_out    = v_s[RB-1];
	assign root_out = root_s[RB-1];
	assign pay_out  = pay_s[RB-1];
endmodule

>>> rtl/spc_div.sv
module spc_div #(
	parameter int NW = 48,
	parameter int DW = 25,
	parameter int PW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             v_in,
	input  logic [NW-1:0]    numx,
	input  logic [NW-1:0]    numy,
	input  logic [DW-1:0]    d,
	input  logic [PW-1:0]    pay_in,
	output logic             v_out,
	output logic [NW-DW-1:0] qx,
	output logic [NW-DW-1:0] qy,
	output logic [PW-1:0]    pay_out
);
	// The quotient is known to fit NW-DW bits, so the top DW numerator
	// bits already lie below the divisor and start as the remainder.
	localparam int QW = NW - DW;

	logic          v_s   [0:QW-1];
	logic [DW-1:0] rx_s  [0:QW-1];
	logic [DW-1:0] ry_s  [0:QW-1];
	logic [QW-1:0] lx_s  [0:QW-1];
	logic [QW-1:0] ly_s  [0:QW-1];
	logic [QW-1:0] qx_s  [0:QW-1];
	logic [QW-1:0] qy_s  [0:QW-1];
	logic [DW-1:0] d_s   [0:QW-1];
	logic [PW-1:0] pay_s [0:QW-1];

	// One quotient bit per stage for both lanes against a shared divisor.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic          cur_v;
		logic [DW-1:0] cur_rx, cur_ry, cur_d;
		logic [QW-1:0] cur_lx, cur_ly, cur_qx, cur_qy;
		logic [PW-1:0] cur_pay;
		logic [DW:0]   tx, ty, dd;
		logic          gex, gey;

		if (k == 0) begin : g_first
			assign cur_v   = v_in;
			assign cur_rx  = numx[NW-1 -: DW];
			assign cur_ry  = numy[NW-1 -: DW];
			assign cur_lx  = numx[QW-1:0];
			assign cur_ly  = numy[QW-1:0];
			assign cur_qx  = '0;
			assign cur_qy  = '0;
			assign cur_d   = d;
			assign cur_pay = pay_in;
		end else begin : g_next
			assign cur_v   = v_s[k-1];
			assign cur_rx  = rx_s[k-1];
			assign cur_ry  = ry_s[k-1];
			assign cur_lx  = lx_s[k-1];
			assign cur_ly  = ly_s[k-1];
			assign cur_qx  = qx_s[k-1];
			assign cur_qy  = qy_s[k-1];
			assign cur_d   = d_s[k-1];
			assign cur_pay = pay_s[k-1];
		end

		assign tx  = {cur_rx, cur_lx[QW-1]};
		assign ty  = {cur_ry, cur_ly[QW-1]};
		assign dd  = {1'b0, cur_d};
		assign gex = tx >= dd;
		assign gey = ty >= dd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k]  <= gex ? DW'(tx - dd) : tx[DW-1:0];
				ry_s[k]  <= gey ? DW'(ty - dd) : ty[DW-1:0];
				lx_s[k]  <= cur_lx << 1;
				ly_s[k]  <= cur_ly << 1;
				qx_s[k]  <= {cur_qx[QW-2:0], gex};
				qy_s[k]  <= {cur_qy[QW-2:0], gey};
				d_s[k]   <= cur_d;
				pay_s[k] <= cur_pay;
			end
		end
	end

	assign v_out   = v_s[QW-1];
	assign qx      = qx_s[QW-1];
	assign qy      = qy_s[QW-1];
	assign pay_out = pay_s[QW-1];
endmodule

>>> rtl/spc_back.sv
module spc_back #(
	parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF,
	parameter int IW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nonempty,
	input  logic [IW-1:0]  din,
	output logic           pop,
	spc_out_if.source      result
);
	localparam int W   = COORD_WIDTH;
	localparam int CTW = $bits(spc_pkg::ctrl_t);
	localparam int PW2 = 4 + 2*W + 2*(W+1) + 2 + (W-1);
	localparam int PW3 = 3 + 2*W + 2;
	localparam int QW  = W - 1;

	spc_pkg::ctrl_t       f_ctrl;
	logic signed [W-1:0]  f_ox, f_oy;
	logic [W:0]           f_mx, f_my;
	logic                 f_sgx, f_sgy;
	logic [W-2:0]         f_r;
	logic [2*W+1:0]       f_sqx, f_sqy;
	logic [2*W-1:0]       f_tsq;

	logic                 en;
	logic                 hit_c, pv_c;
	logic [2*W+1:0]       sum_c;

	logic                 v_s1;
	logic [2*W+1:0]       sum_s1;
	logic [PW2-1:0]       pay_s1;

	logic                 sq_v;
	logic [W:0]           root;
	logic [PW2-1:0]       sq_pay;
	logic                 p_hit, p_pv;
	spc_pkg::pk_t         p_pk;
	logic signed [W-1:0]  p_ox, p_oy;
	logic [W:0]           p_mx, p_my;
	logic                 p_sgx, p_sgy;
	logic [W-2:0]         p_r;

	logic                 v_s2;
	logic [2*W-1:0]       numx_s2, numy_s2;
	logic [W:0]           d_s2;
	logic [PW3-1:0]       pay_s2;

	logic                 dv;
	logic [QW-1:0]        qx, qy;
	logic [PW3-1:0]       dpay;
	logic                 e_hit, e_pv, e_use_o;
	logic signed [W-1:0]  e_ox, e_oy;
	logic                 e_sgx, e_sgy;
	logic signed [W:0]    offx, offy, ptx, pty;
	logic signed [W-1:0]  satx, saty;

	logic                 out_v_q;
	logic                 hit_q, pv_q;
	logic signed [W-1:0]  hx_q, hy_q;

	assign {f_ctrl, f_ox, f_oy, f_mx, f_my, f_sgx, f_sgy, f_r, f_sqx, f_sqy, f_tsq} =
		din[CTW + PW2 - 4 + 2*(2*W+2) + 2*W - 1:0];

	// The whole back advances together whenever the result register can move.
	assign en  = !out_v_q || result.ready;
	assign pop = en && nonempty;

	// Distance test against the squared threshold for circle kinds; other kinds keep the direct result.
	always_comb begin
		sum_c = f_sqx + f_sqy;
		hit_c = f_ctrl.circ ? ({2'b00, f_tsq} >= sum_c) : f_ctrl.hit_d;
		pv_c  = hit_c && (f_ctrl.pk != spc_pkg::PK_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= nonempty;
			v_s2 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sum_c;
			pay_s1 <= {hit_c, pv_c, f_ctrl.pk, f_ox, f_oy, f_mx, f_my, f_sgx, f_sgy, f_r};
		end
	end

	// Distance from the squared length.
	spc_sqrt #(
		.N_BITS (2*W+2),
		.PW     (PW2)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s1),
		.rad_in   (sum_s1),
		.pay_in   (pay_s1),
		.v_out    (sq_v),
		.root_out (root),
		.pay_out  (sq_pay)
	);

	assign {p_hit, p_pv, p_pk, p_ox, p_oy, p_mx, p_my, p_sgx, p_sgy, p_r} = sq_pay;

	// Scale each direction component by the radius.
	always_ff @(posedge clk) begin
		if (en) begin
			numx_s2 <= {{(W-1){1'b0}}, p_mx} * {{(W+1){1'b0}}, p_r};
			numy_s2 <= {{(W-1){1'b0}}, p_my} * {{(W+1){1'b0}}, p_r};
			d_s2    <= root;
			pay_s2  <= {p_hit, p_pv, (p_pk == spc_pkg::PK_RECT) || (root == '0),
				p_ox, p_oy, p_sgx, p_sgy};
		end
	end

	spc_div #(
		.NW (2*W),
		.DW (W+1),
		.PW (PW3)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (v_s2),
		.numx    (numx_s2),
		.numy    (numy_s2),
		.d       (d_s2),
		.pay_in  (pay_s2),
		.v_out   (dv),
		.qx      (qx),
		.qy      (qy),
		.pay_out (dpay)
	);

	assign {e_hit, e_pv, e_use_o, e_ox, e_oy, e_sgx, e_sgy} = dpay;

	// Signed offset from the origin, then saturation to the coordinate range.
	always_comb begin
		offx = e_sgx ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
		offy = e_sgy ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
		if (e_use_o) begin
			offx = '0;
			offy = '0;
		end
		ptx = $signed({e_ox[W-1], e_ox}) + offx;
		pty = $signed({e_oy[W-1], e_oy}) + offy;
		if (ptx[W] != ptx[W-1]) satx = ptx[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else satx = ptx[W-1:0];
		if (pty[W] != pty[W-1]) saty = pty[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else saty = pty[W-1:0];
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= e_hit;
			pv_q  <= e_pv;
			hx_q  <= e_pv ? satx : '0;
			hy_q  <= e_pv ? saty : '0;
		end
	end

	assign result.valid       = out_v_q;
	assign result.hit         = hit_q;
	assign result.point_valid = pv_q;
	assign result.hit_x       = hx_q;
	assign result.hit_y       = hy_q;
endmodule

>>> rtl/shape_pair_collision_test.sv
// Shape pair collision test. One pair of shapes per cycle is accepted and one
// result word per cycle is returned while the result side keeps taking them.
// From acceptance to the result, a word passes through two front stages, the
// four-word queue, the distance compare, one stage per root bit of the square
// root (COORD_WIDTH+1), the scaling multiply, one stage per quotient bit of the
// divider (COORD_WIDTH-1) and the result register. A stall on the result side
// holds the back; the front keeps taking words until the queue credit runs out.
module shape_pair_collision_test #(
	parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	spc_in_if.sink    shapes,
	spc_out_if.source result
);
	localparam int W   = COORD_WIDTH;
	localparam int CTW = $bits(spc_pkg::ctrl_t);
	localparam int QWW = CTW + 2*W + 2*(W+1) + 2 + (W-1) + 2*(2*W+2) + 2*W;
	localparam int CNTW = $clog2(spc_pkg::FIFO_DEPTH + 1);

	logic                 push, pop, nonempty;
	logic [CNTW-1:0]      count;
	spc_pkg::ctrl_t       ctrl;
	logic signed [W-1:0]  ox, oy;
	logic [W:0]           mx, my;
	logic                 sgx, sgy;
	logic [W-2:0]         r;
	logic [2*W+1:0]       sqx, sqy;
	logic [2*W-1:0]       tsq;
	logic [QWW-1:0]       qin, qout;

	// Front: accept and classify.
	spc_front #(
		.COORD_WIDTH (W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.shapes     (shapes),
		.fifo_count (count),
		.push       (push),
		.ctrl       (ctrl),
		.ox         (ox),
		.oy         (oy),
		.mx         (mx),
		.my         (my),
		.sgx        (sgx),
		.sgy        (sgy),
		.r          (r),
		.sqx        (sqx),
		.sqy        (sqy),
		.tsq        (tsq)
	);

	assign qin = {ctrl, ox, oy, mx, my, sgx, sgy, r, sqx, sqy, tsq};

	// Queue between front and back.
	spc_fifo #(
		.WIDTH (QWW),
		.DEPTH (spc_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (qin),
		.pop      (pop),
		.dout     (qout),
		.nonempty (nonempty),
		.count    (count)
	);

	// Back: distance, root, scaling and result.
	spc_back #(
		.COORD_WIDTH (W),
		.IW          (QWW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.din      (qout),
		.pop      (pop),
		.result   (result)
	);
endmodule

>>> rtl/spc_checker.sv
`include "assert_macros.svh"

module spc_checker #(
	parameter int COORD_WIDTH = spc_pkg::COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   r_valid,
	input logic                   r_ready,
	input logic                   r_hit,
	input logic                   r_pv,
	input logic [COORD_WIDTH-1:0] r_x,
	input logic [COORD_WIDTH-1:0] r_y
);
	// A result word offered and not taken stays offered.
	`ASSERT_NEXT(a_valid_holds, clk, arst_n, r_valid && !r_ready, r_valid)

	// An intersection point is only reported for a hit.
	`ASSERT_IMPLIES(a_pv_needs_hit, clk, arst_n, r_valid && r_pv, r_hit)

	// Without a valid point the coordinates read as zero.
	`ASSERT_IMPLIES(a_point_zero, clk, arst_n, r_valid && !r_pv, r_x == '0 && r_y == '0)
endmodule

bind shape_pair_collision_test spc_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_spc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_hit   (result.hit),
	.r_pv    (result.point_valid),
	.r_x     (result.hit_x),
	.r_y     (result.hit_y)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int CW = spc_pkg::COORD_WIDTH_DEF;
	localparam longint C_MAX = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint C_MIN = -(longint'(1) <<< (CW - 1));
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0]           cmd;
		logic signed [CW-1:0] a_x;
		logic signed [CW-1:0] a_y;
		logic signed [CW-1:0] a_x2;
		logic signed [CW-1:0] a_y2;
		logic [CW-2:0]        a_radius;
		logic signed [CW-1:0] b_x;
		logic signed [CW-1:0] b_y;
		logic signed [CW-1:0] b_x2;
		logic signed [CW-1:0] b_y2;
		logic [CW-2:0]        b_radius;
	} shape_word_t;

	typedef struct packed {
		logic                 hit;
		logic                 point_valid;
		logic signed [CW-1:0] hit_x;
		logic signed [CW-1:0] hit_y;
	} contact_t;

	typedef struct {
		shape_word_t word;
		bit          typed;
		contact_t    contact;
	} stim_row_t;

	logic clk;
	logic arst_n;

	spc_in_if  shapes_if ();
	spc_out_if result_if ();

	shape_pair_collision_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.shapes (shapes_if),
		.result (result_if)
	);

	contact_t  contacts_due[$];
	stim_row_t rows_in_flight[$];
	stim_row_t stim_tab[$];
	int        fail_count = 0;
	int        quiet_cycles = 0;
	int        src_idle_pct = 0;
	int        snk_stall_pct = 0;
	int        hold_req = 0;

	// Clock; the single reset at the start of the run is in the main sequence.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Integer square root, rounded down.
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned square(longint v);
		longint unsigned m;
		m = v < 0 ? longint'(-v) : v;
		return m * m;
	endfunction

	function automatic longint scale_toward(longint dir, longint unsigned r,
		longint unsigned d);
		longint unsigned m;
		longint unsigned q;
		m = dir < 0 ? longint'(-dir) : dir;
		q = (m * r) / d;
		return dir < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [CW-1:0] clip(longint v);
		if (v > C_MAX) v = C_MAX;
		if (v < C_MIN) v = C_MIN;
		return v[CW-1:0];
	endfunction

	function automatic longint halve_down(longint s);
		return s >= 0 ? s / 2 : -((-s + 1) / 2);
	endfunction

	// Point at distance r from the origin towards origin plus the direction.
	function automatic void step_along(longint ox, longint oy, longint dx,
		longint dy, longint unsigned r, output longint px, output longint py);
		longint unsigned d;
		d = root_floor(square(dx) + square(dy));
		if (d == 0) begin
			px = ox;
			py = oy;
		end else begin
			px = ox + scale_toward(dx, r, d);
			py = oy + scale_toward(dy, r, d);
		end
	endfunction

	// Expected contact for one shape pair word.
	function automatic contact_t predict_contact(shape_word_t w);
		contact_t        c;
		longint          ax, ay, ax2, ay2, bx, by, bx2, by2, cx, cy, px, py;
		longint unsigned ar, br, rs;
		ax = w.a_x; ay = w.a_y; ax2 = w.a_x2; ay2 = w.a_y2;
		bx = w.b_x; by = w.b_y; bx2 = w.b_x2; by2 = w.b_y2;
		ar = w.a_radius; br = w.b_radius;
		px = 0; py = 0;
		c = '0;
		case (w.cmd)
			spc_pkg::CMD_PT_PT: c.hit = (ax == bx) && (ay == by);
			spc_pkg::CMD_PT_RECT: c.hit = !(ax < bx || ax > bx2 || ay < by || ay > by2);
			spc_pkg::CMD_PT_CIRC: c.hit = square(ax - bx) + square(ay - by) <= br * br;
			spc_pkg::CMD_RECT_RECT: begin
				c.hit = !(ax > bx2 || ay > by2 || ax2 < bx || ay2 < by);
				if (c.hit) begin
					px = halve_down((ax > bx ? ax : bx) + (ax2 < bx2 ? ax2 : bx2));
					py = halve_down((ay > by ? ay : by) + (ay2 < by2 ? ay2 : by2));
				end
			end
			spc_pkg::CMD_RECT_CIRC: begin
				cx = bx < ax ? ax : (bx > ax2 ? ax2 : bx);
				cy = by < ay ? ay : (by > ay2 ? ay2 : by);
				c.hit = square(cx - bx) + square(cy - by) <= br * br;
				if (c.hit) step_along(bx, by, cx - bx, cy - by, br, px, py);
			end
			spc_pkg::CMD_CIRC_CIRC: begin
				rs = ar + br;
				c.hit = square(bx - ax) + square(by - ay) <= rs * rs;
				if (c.hit) step_along(ax, ay, bx - ax, by - ay, ar, px, py);
			end
			default: c.hit = 1'b0;
		endcase
		c.point_valid = c.hit && (w.cmd == spc_pkg::CMD_RECT_RECT ||
			w.cmd == spc_pkg::CMD_RECT_CIRC || w.cmd == spc_pkg::CMD_CIRC_CIRC);
		if (c.point_valid) begin
			c.hit_x = clip(px);
			c.hit_y = clip(py);
		end
		return c;
	endfunction

	function automatic logic signed [CW-1:0] near_coord();
		return CW'($signed($urandom_range(4000)) - 2000);
	endfunction

	// Mostly small overlapping shapes so that hits are common; some full range.
	function automatic shape_word_t random_pair();
		shape_word_t w;
		logic [287:0] raw;
		int          pick;
		pick = $urandom_range(19);
		if (pick == 0) w.cmd = CMD_SPARE_6 + 3'($urandom_range(1));
		else w.cmd = 3'($urandom_range(5));
		if ($urandom_range(99) < 15) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
			w = raw[$bits(shape_word_t)-1:0];
			if (pick == 0) w.cmd = CMD_SPARE_6 + 3'($urandom_range(1));
			else w.cmd = 3'($urandom_range(5));
		end else begin
			w.a_x = near_coord(); w.a_y = near_coord();
			w.a_x2 = w.a_x + CW'($urandom_range(1500));
			w.a_y2 = w.a_y + CW'($urandom_range(1500));
			w.b_x = near_coord(); w.b_y = near_coord();
			w.b_x2 = w.b_x + CW'($urandom_range(1500));
			w.b_y2 = w.b_y + CW'($urandom_range(1500));
			w.a_radius = (CW-1)'($urandom_range(1500));
			w.b_radius = (CW-1)'($urandom_range(1500));
			if ($urandom_range(9) == 0) begin
				// Occasionally an inverted rectangle.
				w.a_x2 = w.a_x - CW'($urandom_range(300));
				w.b_y2 = w.b_y - CW'($urandom_range(300));
			end
			if (w.cmd == spc_pkg::CMD_PT_PT && $urandom_range(1)) begin
				w.b_x = w.a_x;
				w.b_y = w.a_y;
			end
		end
		return w;
	endfunction

	function automatic void add_row(logic [2:0] cmd, int ax, int ay, int ax2, int ay2,
		int ar, int bx, int by, int bx2, int by2, int br, bit typed, contact_t c);
		stim_row_t row;
		row.word = {cmd, CW'(ax), CW'(ay), CW'(ax2), CW'(ay2), (CW-1)'(ar),
			CW'(bx), CW'(by), CW'(bx2), CW'(by2), (CW-1)'(br)};
		row.typed = typed;
		row.contact = c;
		stim_tab.insert(stim_tab.size(), row);
	endfunction

	// Offer one word, idling first as the current phase asks.
	task automatic send_word(stim_row_t row);
		while ($urandom_range(99) < src_idle_pct) begin
			shapes_if.valid <= 1'b0;
			@(posedge clk);
		end
		rows_in_flight.insert(rows_in_flight.size(), row);
		shapes_if.valid    <= 1'b1;
		shapes_if.cmd      <= row.word.cmd;
		shapes_if.a_x      <= row.word.a_x;
		shapes_if.a_y      <= row.word.a_y;
		shapes_if.a_x2     <= row.word.a_x2;
		shapes_if.a_y2     <= row.word.a_y2;
		shapes_if.a_radius <= row.word.a_radius;
		shapes_if.b_x      <= row.word.b_x;
		shapes_if.b_y      <= row.word.b_y;
		shapes_if.b_x2     <= row.word.b_x2;
		shapes_if.b_y2     <= row.word.b_y2;
		shapes_if.b_radius <= row.word.b_radius;
		do @(posedge clk); while (!shapes_if.ready);
	endtask

	task automatic send_random(int count);
		stim_row_t row;
		repeat (count) begin
			row.word = random_pair();
			row.typed = 1'b0;
			row.contact = '0;
			send_word(row);
		end
	endtask

	// Receiver: random stalls, plus a long hold-off when asked.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// Input monitor, result checker and watchdog.
	always @(posedge clk) begin
		stim_row_t row;
		contact_t  want;
		bit        moved;
		moved = 1'b0;
		if (arst_n && shapes_if.valid && shapes_if.ready) begin
			moved = 1'b1;
			row = rows_in_flight.pop_front();
			contacts_due.insert(contacts_due.size(),
				row.typed ? row.contact : predict_contact(row.word));
		end
		if (arst_n && result_if.valid && result_if.ready) begin
			moved = 1'b1;
			if (contacts_due.size() == 0) begin
				$error("result word with no expectation waiting");
				fail_count++;
			end else begin
				want = contacts_due.pop_front();
				if (result_if.hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, result_if.hit);
					fail_count++;
				end
				if (result_if.point_valid !== want.point_valid) begin
					$error("point_valid: expected %0d, actual %0d", want.point_valid,
						result_if.point_valid);
					fail_count++;
				end
				if (result_if.hit_x !== want.hit_x) begin
					$error("hit_x: expected %0d, actual %0d", want.hit_x, result_if.hit_x);
					fail_count++;
				end
				if (result_if.hit_y !== want.hit_y) begin
					$error("hit_y: expected %0d, actual %0d", want.hit_y, result_if.hit_y);
					fail_count++;
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("shape_pair_collision_test test failed");
			$finish;
		end
	end

	// Main sequence: directed table, then random phases.
	initial begin
		contact_t none;
		none = '0;
		arst_n = 1'b0;
		shapes_if.valid = 1'b0;
		shapes_if.cmd = spc_pkg::CMD_PT_PT;
		{shapes_if.a_x, shapes_if.a_y, shapes_if.a_x2, shapes_if.a_y2} = '0;
		{shapes_if.b_x, shapes_if.b_y, shapes_if.b_x2, shapes_if.b_y2} = '0;
		shapes_if.a_radius = '0;
		shapes_if.b_radius = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Typed rows: coincident and distinct points, spare kinds, full-range rects.
		add_row(spc_pkg::CMD_PT_PT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			'{1'b1, 1'b0, '0, '0});
		add_row(spc_pkg::CMD_PT_PT, 5, 0, 0, 0, 0, 6, 0, 0, 0, 0, 1, none);
		add_row(CMD_SPARE_6, 0, 0, 9, 9, 9, 0, 0, 9, 9, 9, 1, none);
		add_row(CMD_SPARE_7, -1, -1, -1, -1, 8388607, -1, -1, -1, -1, 8388607, 1, none);
		add_row(spc_pkg::CMD_RECT_RECT, -8388608, -8388608, 8388607, 8388607, 0,
			-8388608, -8388608, 8388607, 8388607, 0, 1, '{1'b1, 1'b1, -24'sd1, -24'sd1});
		add_row(spc_pkg::CMD_PT_PT, 8388607, -8388608, 0, 0, 0, 8388607, -8388608, 0, 0, 0,
			1, '{1'b1, 1'b0, '0, '0});
		// Predicted rows: every kind but point-point, edges, zero distance, inverted and saturating.
		add_row(spc_pkg::CMD_PT_RECT, 10, 20, 0, 0, 0, 10, 20, 10, 20, 0, 0, none);
		add_row(spc_pkg::CMD_PT_RECT, 9, 20, 0, 0, 0, 10, 20, 30, 40, 0, 0, none);
		add_row(spc_pkg::CMD_PT_CIRC, 300, 400, 0, 0, 0, 0, 0, 0, 0, 500, 0, none);
		add_row(spc_pkg::CMD_PT_CIRC, 301, 400, 0, 0, 0, 0, 0, 0, 0, 500, 0, none);
		add_row(spc_pkg::CMD_RECT_RECT, 0, 0, 100, 100, 0, 100, 100, 200, 200, 0, 0, none);
		add_row(spc_pkg::CMD_RECT_RECT, -7, -7, 3, 2, 0, -4, -5, 9, 9, 0, 0, none);
		add_row(spc_pkg::CMD_RECT_RECT, 0, 0, 100, 100, 0, 101, 0, 200, 100, 0, 0, none);
		add_row(spc_pkg::CMD_RECT_RECT, 50, 50, 10, 10, 0, 0, 0, 100, 100, 0, 0, none);
		add_row(spc_pkg::CMD_RECT_CIRC, 0, 0, 100, 100, 0, 50, 50, 0, 0, 20, 0, none);
		add_row(spc_pkg::CMD_RECT_CIRC, 0, 0, 100, 100, 0, 130, 140, 0, 0, 50, 0, none);
		add_row(spc_pkg::CMD_RECT_CIRC, 0, 0, 100, 100, 0, 130, 140, 0, 0, 49, 0, none);
		add_row(spc_pkg::CMD_RECT_CIRC, 50, 50, 10, 10, 0, 30, 30, 0, 0, 40, 0, none);
		add_row(spc_pkg::CMD_RECT_CIRC, 8388000, 0, 8388607, 10, 0, 8388300, 5, 0, 0,
			8388607, 0, none);
		add_row(spc_pkg::CMD_CIRC_CIRC, 7, -9, 0, 0, 30, 7, -9, 0, 0, 40, 0, none);
		add_row(spc_pkg::CMD_CIRC_CIRC, 0, 0, 0, 0, 300, 400, 300, 0, 0, 200, 0, none);
		add_row(spc_pkg::CMD_CIRC_CIRC, 8388000, 0, 0, 0, 8388607, 8388607, 0, 0, 0, 0, 0,
			none);
		add_row(spc_pkg::CMD_CIRC_CIRC, -8388608, -8388608, 0, 0, 8388607, 8388607,
			8388607, 0, 0, 8388607, 0, none);
		foreach (stim_tab[i]) send_word(stim_tab[i]);

		send_random(300);
		src_idle_pct = 72;
		send_random(300);
		src_idle_pct = 0;
		snk_stall_pct = 72;
		send_random(300);
		src_idle_pct = 21;
		snk_stall_pct = 21;
		send_random(250);

		// Long receiver hold-off while words keep coming, so the input stalls.
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_req = hold_req + 1;
		send_random(100);
		shapes_if.valid <= 1'b0;

		while (contacts_due.size() != 0 || rows_in_flight.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("shape_pair_collision_test test passed");
		end else begin
			$display("shape_pair_collision_test test failed");
		end
		$finish;
	end

endmodule
